// ===== hw/rtl/fqd_pkg.sv =====
// Package: shared types and codes of the FIFO queue with delete by identifier.
`default_nettype none
package fqd_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int PSTATE_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PSTATE_W-1:0] proc_state_t;

  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;
  localparam cmd_t CMD_NONE   = 2'd3;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage
`default_nettype wire

// ===== hw/rtl/fqd_in_if.sv =====
// Interface: command channel (valid, ready and command payload).
`default_nettype none
interface fqd_in_if #(
  parameter int ID_BITS = 8
);
  import fqd_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [ID_BITS-1:0] proc_id;
  proc_state_t        new_state;
  logic               release_record;

  modport source (output valid, cmd, proc_id, new_state, release_record, input ready);
  modport sink   (input valid, cmd, proc_id, new_state, release_record, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fqd_out_if.sv =====
// Interface: result channel (valid, ready and result payload).
`default_nettype none
interface fqd_out_if #(
  parameter int ID_BITS = 8,
  parameter int CNT_W   = 5
);
  import fqd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] result_id;
  status_t            status;
  proc_state_t        state_out;
  logic               release_out;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, result_id, status, state_out, release_out, entry_count,
                  input ready);
  modport sink   (input valid, result_id, status, state_out, release_out, entry_count,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fifo_queue_with_delete_by_id_top.sv =====
// Top level: FIFO queue of process identifiers with pop and delete by identifier.
// Push, full, empty and unused commands go straight to the result stage; pop and
//   delete read and compare entries from the head, and on a match shift the
//   entries behind it down one slot.
// Throughput: one transaction at a time; the memory port (one read, one write per
//   cycle) drives the scan and the gap closing.
// Reset: rst_n synchronous, active low; clears occupancy, sequencer and out valid.
`default_nettype none
module fifo_queue_with_delete_by_id_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fqd_in_if.sink     in_chan,
  fqd_out_if.source  out_chan
);
  import fqd_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // One-hot sequencer: read an entry, compare it, then close the gap by
  // reading slot idx+1 and writing it back to slot idx.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_SH_RD = 6'b001000,
    S_SH_WR = 6'b010000,
    S_FIN   = 6'b100000
  } fsm_t;

  fsm_t state_r, state_nxt;

  // Entry storage, head at slot 0; registered read data.
  logic [ID_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // Captured command transaction.
  cmd_t               cmd_r, cmd_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  proc_state_t        nst_r, nst_nxt;
  logic               rel_r, rel_nxt;

  // Pending result, moved to the output register in S_FIN.
  logic [ID_BITS-1:0] res_id_r, res_id_nxt;
  status_t            res_st_r, res_st_nxt;
  proc_state_t        res_ps_r, res_ps_nxt;
  logic               res_rel_r, res_rel_nxt;
  logic               res_dec_r, res_dec_nxt;

  // Output register.
  logic               out_valid_r;
  logic [ID_BITS-1:0] out_id_r;
  status_t            out_st_r;
  proc_state_t        out_ps_r;
  logic               out_rel_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic               in_fire;
  logic               out_free;
  logic               match;
  logic [CNT_W:0]     idx_p1;
  logic [CNT_W:0]     idx_p2;
  logic [IDX_W-1:0]   idx_inc;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign idx_inc = idx_r + 1'b1;
  assign idx_p1  = (CNT_W + 1)'(idx_r) + 1'b1;
  assign idx_p2  = (CNT_W + 1)'(idx_r) + 2'd2;
  // Pop takes slot 0 whatever it holds; delete needs an identifier match.
  assign match   = (cmd_r == CMD_POP) || (rd_data_r == id_r);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_id   = out_id_r;
  assign out_chan.status      = out_st_r;
  assign out_chan.state_out   = out_ps_r;
  assign out_chan.release_out = out_rel_r;
  assign out_chan.entry_count = out_cnt_r;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    nst_nxt     = nst_r;
    rel_nxt     = rel_r;
    res_id_nxt  = res_id_r;
    res_st_nxt  = res_st_r;
    res_ps_nxt  = res_ps_r;
    res_rel_nxt = res_rel_r;
    res_dec_nxt = res_dec_r;
    mem_we      = 1'b0;
    wr_addr     = idx_r;
    wr_data     = rd_data_r;
    rd_addr     = (state_r == S_SH_RD) ? idx_inc : idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_chan.cmd;
          id_nxt      = in_chan.proc_id;
          nst_nxt     = in_chan.new_state;
          rel_nxt     = in_chan.release_record;
          idx_nxt     = '0;
          res_id_nxt  = '0;
          res_st_nxt  = ST_DONE;
          res_ps_nxt  = '0;
          res_rel_nxt = 1'b0;
          res_dec_nxt = 1'b0;
          state_nxt   = S_FIN;
          unique case (in_chan.cmd)
            CMD_PUSH: begin
              if (count_r >= DEPTH_C) begin
                res_st_nxt = ST_FULL;
              end else begin
                // Append at the tail right away.
                mem_we     = 1'b1;
                wr_addr    = count_r[IDX_W-1:0];
                wr_data    = in_chan.proc_id;
                count_nxt  = count_r + 1'b1;
                res_id_nxt = in_chan.proc_id;
                res_ps_nxt = in_chan.new_state;
              end
            end
            CMD_POP, CMD_DELETE: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              res_st_nxt = ST_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          res_id_nxt  = rd_data_r;
          res_st_nxt  = ST_DONE;
          res_ps_nxt  = nst_r;
          res_rel_nxt = (cmd_r == CMD_DELETE) && rel_r;
          res_dec_nxt = 1'b1;
          state_nxt   = (idx_p1 < (CNT_W + 1)'(count_r)) ? S_SH_RD : S_FIN;
        end else if (idx_p1 >= (CNT_W + 1)'(count_r)) begin
          res_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_RD;
        end
      end
      S_SH_RD: begin
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // Move slot idx+1 down into slot idx.
        mem_we    = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data_r;
        idx_nxt   = idx_inc;
        state_nxt = (idx_p2 < (CNT_W + 1)'(count_r)) ? S_SH_RD : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          count_nxt = count_r - CNT_W'(res_dec_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the transaction, pending result and output.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    nst_r     <= nst_nxt;
    rel_r     <= rel_nxt;
    res_id_r  <= res_id_nxt;
    res_st_r  <= res_st_nxt;
    res_ps_r  <= res_ps_nxt;
    res_rel_r <= res_rel_nxt;
    res_dec_r <= res_dec_nxt;
    if ((state_r == S_FIN) && out_free) begin
      out_id_r  <= res_id_r;
      out_st_r  <= res_st_r;
      out_ps_r  <= res_ps_r;
      out_rel_r <= res_rel_r;
      out_cnt_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fqd_checker.sv =====
// Checker: port-level assertions for the FIFO queue with delete, and its bind.
`default_nettype none
module fqd_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [ID_BITS-1:0]                 result_id,
  input wire fqd_pkg::status_t                   status,
  input wire fqd_pkg::proc_state_t               state_out,
  input wire logic                               release_out,
  input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   entry_count
);
  import fqd_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // A failed operation affects no record.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_DONE) |->
      (result_id == '0 && state_out == '0 && !release_out))
    else $error("failed operation reports an affected record");

  // Occupancy never exceeds the queue depth; a full report means a full queue.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (entry_count <= CNT_W'(QUEUE_DEPTH) &&
      (status != ST_FULL || entry_count == CNT_W'(QUEUE_DEPTH))))
    else $error("entry count out of range");

  // An accepted command makes the block busy: ready is low in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted back to back");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_id) && $stable(status) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_delete_by_id_top fqd_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .ID_BITS     (ID_BITS)
) u_fqd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .result_id   (out_chan.result_id),
  .status      (out_chan.status),
  .state_out   (out_chan.state_out),
  .release_out (out_chan.release_out),
  .entry_count (out_chan.entry_count)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench: directed and randomized command traffic with a self-checking ready-list scoreboard.
`timescale 1ns / 1ps
import fqd_pkg::*;

localparam int QDEPTH   = 16;
localparam int PID_BITS = 8;
localparam int CNT_BITS = 5;

typedef logic [PID_BITS-1:0] pid_t;

typedef struct packed {
  pid_t                result_id;
  status_t             status;
  proc_state_t         state_out;
  logic                release_out;
  logic [CNT_BITS-1:0] entry_count;
} fqd_result_t;

class ready_list_ledger;
  pid_t        held_ids[$];
  fqd_result_t pending[$];
  int          errors;
  int          checked;
  int          n_push, n_pop, n_del_hit, n_del_miss, n_full, n_empty, n_idle;

  // Apply one accepted command to the shadow list and queue its result.
  function void note_command(cmd_t cmd, pid_t pid, proc_state_t nst, logic rel);
    fqd_result_t r;
    int hit;
    r = '0;
    r.status = ST_DONE;
    hit = -1;
    case (cmd)
      CMD_PUSH: begin
        if (held_ids.size() >= QDEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          held_ids.push_back(pid);
          r.result_id = pid;
          r.state_out = nst;
          n_push++;
        end
      end
      CMD_POP: begin
        if (held_ids.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.result_id = held_ids.pop_front();
          r.state_out = nst;
          n_pop++;
        end
      end
      CMD_DELETE: begin
        if (held_ids.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          foreach (held_ids[i])
            if (hit < 0 && held_ids[i] == pid) hit = i;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
            n_del_miss++;
          end else begin
            held_ids.delete(hit);
            r.result_id   = pid;
            r.state_out   = nst;
            r.release_out = rel;
            n_del_hit++;
          end
        end
      end
      default: n_idle++;
    endcase
    r.entry_count = CNT_BITS'(held_ids.size());
    pending.push_back(r);
  endfunction

  // Compare one delivered result against the oldest queued one.
  function void check_result(fqd_result_t got);
    fqd_result_t want;
    if (pending.size() == 0) begin
      $error("result with nothing pending: id %0d status %0d count %0d",
             got.result_id, got.status, got.entry_count);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.result_id !== want.result_id) begin
      $error("result_id: expected %0d, actual %0d", want.result_id, got.result_id);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.state_out !== want.state_out) begin
      $error("state_out: expected %0d, actual %0d", want.state_out, got.state_out);
      errors++;
    end
    if (got.release_out !== want.release_out) begin
      $error("release_out: expected %0d, actual %0d", want.release_out, got.release_out);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
      errors++;
    end
  endfunction
endclass

module testbench;
  // Longest correct wait with no transaction: a full-length delete scan plus the
  // longest receiver stall plus the longest sender gap, taken many times over.
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n;

  fqd_in_if  #(.ID_BITS(PID_BITS))                  in_chan ();
  fqd_out_if #(.ID_BITS(PID_BITS), .CNT_W(CNT_BITS)) out_chan ();

  fifo_queue_with_delete_by_id_top #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_BITS    (PID_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #5 clk = ~clk;

  ready_list_ledger ledger = new();

  // Sender pacing: bursts of commands offered without a pause, separated by random gaps.
  // A calm stretch drops the gaps entirely.
  int burst_left = 0;
  bit calm       = 1'b0;

  // Offer one command and hold it until the block takes it, then predict it.
  task automatic send_cmd(cmd_t cmd, pid_t pid, proc_state_t nst, logic rel);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = calm ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    // Drop valid only when a gap follows, so valid never toggles within one step.
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.cmd            <= cmd;
    in_chan.proc_id        <= pid;
    in_chan.new_state      <= nst;
    in_chan.release_record <= rel;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    ledger.note_command(cmd, pid, nst, rel);
  endtask

  // Pick the next random command from the shadow list so that deletes mostly hit,
  // the list swings between empty and full, and duplicate identifiers show up.
  task automatic send_random(int push_weight);
    int   roll;
    int   held;
    cmd_t cmd;
    pid_t pid;
    held = ledger.held_ids.size();
    roll = $urandom_range(0, 99);
    if (roll < 4)
      cmd = CMD_NONE;
    else if (roll < 4 + push_weight)
      cmd = CMD_PUSH;
    else if (roll < 4 + push_weight + (96 - push_weight) / 2)
      cmd = CMD_POP;
    else
      cmd = CMD_DELETE;
    // Half the identifiers come from a narrow pool to force duplicates.
    pid = ($urandom_range(0, 1) == 0) ? pid_t'($urandom_range(0, 15))
                                      : pid_t'($urandom_range(0, 255));
    if (cmd == CMD_DELETE && held > 0 && $urandom_range(0, 3) != 0)
      pid = ledger.held_ids[$urandom_range(0, held - 1)];
    send_cmd(cmd, pid, proc_state_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // Result side: stall on its own pattern, switching between always ready,
  // randomly scattered stalls and stall runs of random length.
  initial begin : result_sink
    int span;
    int mode;
    int hold;
    span = 0;
    mode = 0;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = $urandom_range(100, 300);
        mode = $urandom_range(0, 2);
      end
      span--;
      case (mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (hold > 0) begin
            hold--;
            out_chan.ready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 30);
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Check each delivered result and watch for a stuck block.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      ledger.check_result({out_chan.result_id, out_chan.status, out_chan.state_out,
                           out_chan.release_out, out_chan.entry_count});
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               IDLE_LIMIT, ledger.pending.size());
      $display("fifo_queue_with_delete_by_id_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    int push_weight;
    // Hold every input at a known value through reset.
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.cmd            <= CMD_NONE;
    in_chan.proc_id        <= '0;
    in_chan.new_state      <= '0;
    in_chan.release_record <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue pop and delete, the unused command, then fill to
    // capacity with the identifier extremes and some duplicates.
    send_cmd(CMD_POP,    8'hFF, 3'd7, 1'b1);
    send_cmd(CMD_DELETE, 8'h00, 3'd3, 1'b1);
    send_cmd(CMD_NONE,   8'hFF, 3'd7, 1'b1);
    send_cmd(CMD_PUSH,   8'h00, 3'd7, 1'b1);   // release ignored on push
    send_cmd(CMD_PUSH,   8'hFF, 3'd0, 1'b0);
    for (int i = 0; i < QDEPTH - 2; i++)
      send_cmd(CMD_PUSH, pid_t'(8'h10 + i % 10), proc_state_t'(i % 8),
               1'($urandom_range(0, 1)));
    // Push into a full queue, delete the second entry, a duplicate, the head,
    // then a miss and a pop with release requested.
    send_cmd(CMD_PUSH,   8'h5A, 3'd5, 1'b1);
    send_cmd(CMD_DELETE, 8'hFF, 3'd5, 1'b1);
    send_cmd(CMD_DELETE, 8'h13, 3'd2, 1'b0);
    send_cmd(CMD_DELETE, 8'h00, 3'd6, 1'b1);
    send_cmd(CMD_DELETE, 8'h77, 3'd1, 1'b1);
    send_cmd(CMD_POP,    8'hAA, 3'd4, 1'b1);   // release ignored on pop

    // Random: shift the push weight every stretch so the list drifts between
    // empty and full; skip counting the unused command.
    sent = 0;
    push_weight = 48;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 150 == 0) begin
        push_weight = $urandom_range(25, 70);
        calm = ($urandom_range(0, 3) == 0);
      end
      send_random(push_weight);
      if (in_chan.cmd != CMD_NONE) sent++;
    end
    in_chan.valid <= 1'b0;

    // Drain: wait for every pending result, then allow for stray output.
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d pushes, %0d pops, %0d deletes hit, %0d missed,",
             ledger.checked, ledger.n_push, ledger.n_pop, ledger.n_del_hit,
             ledger.n_del_miss);
    $display("  %0d full drops, %0d empty-queue commands, %0d unused commands.",
             ledger.n_full, ledger.n_empty, ledger.n_idle);
    if (ledger.errors == 0)
      $display("fifo_queue_with_delete_by_id_top verification clean");
    else
      $display("fifo_queue_with_delete_by_id_top verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/fqd_pkg.sv
hw/rtl/fqd_in_if.sv
hw/rtl/fqd_out_if.sv
hw/rtl/fifo_queue_with_delete_by_id_top.sv
hw/rtl/fqd_checker.sv
sim/testbench.sv
